// ----- src/atod_pkg.sv -----
package atod_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int WINDOW_LEN   = 32;
  localparam int SAMPLE_BITS  = 18;

  localparam int CH_W   = 2;
  localparam int SB     = SAMPLE_BITS;
  localparam int GAIN_W = 10;
  localparam int Q_BITS = 10;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(358);

  localparam int AVG_W = SAMPLE_BITS;
  localparam int THR_W = SAMPLE_BITS + 1;
  localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int DEN_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = SB + $clog2(WINDOW_LEN);

  localparam int RG_W   = SB + GAIN_W;
  localparam int PROD_W = RG_W + DEN_W;
  localparam int NUM_W  = ((SUM_W + Q_BITS) > PROD_W ? (SUM_W + Q_BITS) : PROD_W) + 1;
  localparam int NQ_W   = NUM_W - Q_BITS;
  localparam int DVD_W  = NQ_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  localparam int CHA_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WIN_DEPTH = NUM_CHANNELS * WINDOW_LEN;
  localparam int WA_W      = $clog2(WIN_DEPTH);

  localparam int IN_DATA_W  = ((CH_W + SB + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CH_W + 1 + AVG_W + THR_W + 7) / 8) * 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_GAIN = '0;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] widx;
    logic             full;
    logic [SB-1:0]    pmax;
    logic [SB-1:0]    pmin;
    logic [AVG_W-1:0] avg;
    logic [THR_W-1:0] thr;
    logic             act;
  } chst_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             act;
    logic [AVG_W-1:0] avg;
    logic [THR_W-1:0] thr;
    logic             bad;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDCH,
    S_UPD,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_WB
  } state_t;

endpackage

// ----- src/atod_div.sv -----
module atod_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [atod_pkg::DEN_W-1:0] den,
  input  logic [atod_pkg::DVD_W-1:0] dvd_a,
  input  logic [atod_pkg::DVD_W-1:0] dvd_b,
  output logic                       done,
  output logic [atod_pkg::DVD_W-1:0] q_a,
  output logic [atod_pkg::DVD_W-1:0] q_b
);
  import atod_pkg::*;

  logic [DEN_W-1:0] den_r;
  logic [DVD_W-1:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [DEN_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0]   ta, tb;
  logic             ga, gb;

  always_comb begin
    ta     = {ra_r, qa_r[DVD_W-1]};
    tb     = {rb_r, qb_r[DVD_W-1]};
    ga     = ta >= {1'b0, den_r};
    gb     = tb >= {1'b0, den_r};
    ra_nxt = ga ? DEN_W'(ta - {1'b0, den_r}) : DEN_W'(ta);
    rb_nxt = gb ? DEN_W'(tb - {1'b0, den_r}) : DEN_W'(tb);
    qa_nxt = {qa_r[DVD_W-2:0], ga};
    qb_nxt = {qb_r[DVD_W-2:0], gb};
    cnt_nxt  = cnt_r + CNT_W'(1);
    busy_nxt = busy_r && (cnt_r != CNT_W'(DVD_W - 1));
    done_nxt = busy_r && (cnt_r == CNT_W'(DVD_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= busy_r ? cnt_nxt : cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      qa_r  <= dvd_a;
      qb_r  <= dvd_b;
      ra_r  <= '0;
      rb_r  <= '0;
    end else if (busy_r) begin
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign done = done_r;
  assign q_a  = qa_r;
  assign q_b  = qb_r;

endmodule

// ----- src/atod_core.sv -----
module atod_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [atod_pkg::CH_W-1:0]   in_ch,
  input  logic [atod_pkg::SB-1:0]     in_sample,
  input  logic [atod_pkg::GAIN_W-1:0] gain,
  input  logic                        out_free,
  output logic                        res_vld,
  output atod_pkg::res_t              res
);
  import atod_pkg::*;

  state_t st_r, st_nxt;

  chst_t            chan_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_vld_r;
  chst_t            chan_q_r;
  logic             chan_qv_r;
  logic [SB-1:0]    win_mem [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_vld_r;
  logic [SB-1:0]    win_q_r;
  logic             win_qv_r;

  logic [CH_W-1:0]  ch_r;
  logic [SB-1:0]    s_r;
  logic             bad_r;
  chst_t            cur_r;
  logic [WA_W-1:0]  waddr_r;
  logic [DEN_W-1:0] den_r;
  logic [IDX_W-1:0] pos_r;

  logic [SUM_W-1:0] nsum_r;
  logic [SB-1:0]    nmax_r, nmin_r;
  logic [IDX_W-1:0] nidx_r;
  logic             nfull_r;
  logic [AVG_W-1:0] navg_r;
  logic [THR_W-1:0] nthr_r;
  logic             nact_r;
  logic [RG_W-1:0]  rg_r;

  logic             in_bad;
  chst_t            cs, wb_st;
  logic [IDX_W-1:0] pos;
  logic [WA_W-1:0]  waddr;
  logic [SB-1:0]    old_s;
  logic [SUM_W-1:0] nsum;
  logic [SB-1:0]    nmax, nmin;
  logic             wrap;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0] num;
  logic [DVD_W-1:0] nq;
  logic             div_start, div_done;
  logic [DVD_W-1:0] q_a, q_b;
  logic [THR_W-1:0] thr_sat;
  logic             win_we, chan_we;

  assign in_bad = int'(in_ch) >= NUM_CHANNELS;

  always_comb begin
    cs    = chan_qv_r ? chan_q_r : '0;
    pos   = (int'(cs.widx) >= WINDOW_LEN) ? '0 : cs.widx;
    waddr = WA_W'(int'(ch_r) * WINDOW_LEN + int'(pos));
    old_s = win_qv_r ? win_q_r : '0;
    nsum  = cur_r.sum - SUM_W'(old_s) + SUM_W'(s_r);
    nmax  = (s_r > cur_r.pmax) ? s_r : cur_r.pmax;
    nmin  = (s_r < cur_r.pmin) ? s_r : cur_r.pmin;
    wrap  = (int'(pos_r) + 1) == WINDOW_LEN;
    prod  = PROD_W'(rg_r) * PROD_W'(den_r);
    num   = (NUM_W'(nsum_r) << Q_BITS) + NUM_W'(prod);
    nq    = DVD_W'(num >> Q_BITS);
    thr_sat = (q_b > DVD_W'(THR_MAX)) ? THR_MAX : THR_W'(q_b);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = in_bad ? S_WB : S_RDCH;
        end
      end
      S_RDCH: st_nxt = S_UPD;
      S_UPD:  st_nxt = (nsum == '0) ? S_WB : S_MUL1;
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          st_nxt = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    win_we    = 1'b0;
    chan_we   = 1'b0;
    res_vld   = 1'b0;
    case (st_r)
      S_IDLE: in_ready  = 1'b1;
      S_UPD:  win_we    = 1'b1;
      S_MUL2: div_start = 1'b1;
      S_WB: begin
        res_vld = out_free;
        chan_we = out_free && !bad_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      chan_vld_r <= '0;
      win_vld_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (chan_we) begin
        chan_vld_r[CHA_W'(ch_r)] <= 1'b1;
      end
      if (win_we) begin
        win_vld_r[waddr_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    wb_st      = cur_r;
    wb_st.sum  = nsum_r;
    wb_st.widx = nidx_r;
    wb_st.full = nfull_r;
    wb_st.pmax = nmax_r;
    wb_st.pmin = nmin_r;
    wb_st.avg  = navg_r;
    wb_st.thr  = nthr_r;
    wb_st.act  = nact_r;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE) begin
      chan_q_r  <= chan_mem[CHA_W'(in_ch)];
      chan_qv_r <= chan_vld_r[CHA_W'(in_ch)];
    end
    if (chan_we) begin
      chan_mem[CHA_W'(ch_r)] <= wb_st;
    end
    if (st_r == S_RDCH) begin
      win_q_r  <= win_mem[waddr];
      win_qv_r <= win_vld_r[waddr];
    end
    if (win_we) begin
      win_mem[waddr_r] <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        ch_r  <= in_ch;
        s_r   <= in_sample;
        bad_r <= in_bad;
      end
      S_RDCH: begin
        cur_r   <= cs;
        pos_r   <= pos;
        waddr_r <= waddr;
        den_r   <= cs.full ? DEN_W'(WINDOW_LEN) : DEN_W'(int'(pos) + 1);
      end
      S_UPD: begin
        nsum_r  <= nsum;
        nmax_r  <= nmax;
        nmin_r  <= nmin;
        nidx_r  <= wrap ? '0 : IDX_W'(int'(pos_r) + 1);
        nfull_r <= cur_r.full | wrap;
        navg_r  <= cur_r.avg;
        nthr_r  <= cur_r.thr;
        nact_r  <= cur_r.act;
      end
      S_MUL1: rg_r <= RG_W'(nmax_r - nmin_r) * RG_W'(gain);
      S_DIV: begin
        if (div_done) begin
          navg_r <= AVG_W'(q_a);
          nthr_r <= thr_sat;
          nact_r <= THR_W'(s_r) > thr_sat;
        end
      end
      default: ;
    endcase
  end

  atod_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (den_r),
    .dvd_a (DVD_W'(nsum_r)),
    .dvd_b (nq),
    .done  (div_done),
    .q_a   (q_a),
    .q_b   (q_b)
  );

  always_comb begin
    res.ch  = ch_r;
    res.bad = bad_r;
    res.act = bad_r ? 1'b0 : nact_r;
    res.avg = bad_r ? '0 : navg_r;
    res.thr = bad_r ? '0 : nthr_r;
  end

endmodule

// ----- src/adaptive_threshold_occupancy_detector.sv -----
// Channel  Role    Handshake             Contents
// in_      slave   in_tvalid/in_tready   channel, sample
// out_     master  out_tvalid/out_tready channel_out, active, average, threshold; tuser bad_channel
// cfg_     APB     psel/penable/pready   range_gain_q10 at byte address 0
//
// An in-range word passes two memory reads, the window update, two multiply steps, a 25-step
// restoring divider and its done strobe before it reaches the output register; with a zero new
// window sum it skips the multiply and divide steps, and an out-of-range word goes straight to it.
// One word is processed at a time; the next is taken the cycle after the result is registered.
// Synchronous active-low reset; window entries and channel state read as zero until written.
// A stalled output holds one result while the next word may already be accepted.
module adaptive_threshold_occupancy_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] channel, [19:2] sample
  input  logic [atod_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] channel_out, [2] active, [20:3] average, [39:21] threshold
  output logic [atod_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] bad_channel
  output logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [atod_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [atod_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [atod_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import atod_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_res_r;
  logic              out_free, res_vld;
  res_t              res;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_GAIN) ? CFG_DW'(gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_GAIN)) begin
      gain_r <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  atod_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tdata[CH_W-1:0]),
    .in_sample (in_tdata[CH_W+SB-1:CH_W]),
    .gain      (gain_r),
    .out_free  (out_free),
    .res_vld   (res_vld),
    .res       (res)
  );

  assign out_free    = !out_vld_r || out_tready;
  assign out_vld_nxt = res_vld || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_res_r.thr, out_res_r.avg, out_res_r.act, out_res_r.ch});
  assign out_tuser  = out_res_r.bad;

endmodule

// ----- src/atod_checker.sv -----
module atod_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [atod_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_pready
);
  import atod_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in work");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_DATA_W-1:CH_W] == '0)
    else $error("error word carries nonzero results");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind adaptive_threshold_occupancy_detector atod_checker u_atod_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

// ----- test/occupancy_checker.sv -----
`timescale 1ns / 100ps

module occupancy_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [1:0] channel, [19:2] sample
  input  logic [atod_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] channel_out, [2] active, [20:3] average, [39:21] threshold
  input  logic [atod_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] bad_channel
  input  logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [atod_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [atod_pkg::CFG_DW-1:0]     cfg_pwdata,
  input  logic [atod_pkg::CFG_DW-1:0]     cfg_prdata,
  input  logic                            cfg_pready,
  output int                              open_words,
  output int                              mismatches
);
  import atod_pkg::*;

  logic [GAIN_W-1:0] gain;
  logic [SB-1:0]     history [NUM_CHANNELS][WINDOW_LEN];
  logic [SUM_W-1:0]  run_sum [NUM_CHANNELS];
  logic [IDX_W-1:0]  next_slot [NUM_CHANNELS];
  logic              wrapped [NUM_CHANNELS];
  logic [SB-1:0]     peak [NUM_CHANNELS];
  logic [SB-1:0]     trough [NUM_CHANNELS];
  logic [AVG_W-1:0]  mean [NUM_CHANNELS];
  logic [THR_W-1:0]  trip_level [NUM_CHANNELS];
  logic              occupied [NUM_CHANNELS];
  res_t              pending_detections [$];
  int                mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t: %s is %0d, should be %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic res_t detect_occupancy(input logic [CH_W-1:0] ch,
                                            input logic [SB-1:0] s);
    res_t              r;
    logic [IDX_W-1:0]  pos;
    longint unsigned   den, span, total, num, thr;
    r = '0;
    r.ch = ch;
    if (ch >= NUM_CHANNELS) begin
      r.bad = 1'b1;
      return r;
    end
    pos = next_slot[ch];
    run_sum[ch] = run_sum[ch] - history[ch][pos] + s;
    history[ch][pos] = s;
    if (s > peak[ch]) peak[ch] = s;
    if (s < trough[ch]) trough[ch] = s;
    if (run_sum[ch] != '0) begin
      den = wrapped[ch] ? WINDOW_LEN : longint'(pos) + 1;
      span = peak[ch] - trough[ch];
      total = run_sum[ch];
      mean[ch] = AVG_W'(total / den);
      num = (total << Q_BITS) + span * gain * den;
      thr = num / (den << Q_BITS);
      if (thr > THR_MAX) thr = THR_MAX;
      trip_level[ch] = THR_W'(thr);
      occupied[ch] = (s > thr);
    end
    if (pos == IDX_W'(WINDOW_LEN - 1)) wrapped[ch] = 1'b1;
    next_slot[ch] = pos + 1'b1;
    r.act = occupied[ch];
    r.avg = mean[ch];
    r.thr = trip_level[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      gain = GAIN_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int k = 0; k < WINDOW_LEN; k++) history[c][k] = '0;
        run_sum[c] = '0;
        next_slot[c] = '0;
        wrapped[c] = 1'b0;
        peak[c] = '0;
        trough[c] = '0;
        mean[c] = '0;
        trip_level[c] = '0;
        occupied[c] = 1'b0;
      end
      pending_detections.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.ch  = out_tdata[CH_W-1:0];
        got.act = out_tdata[CH_W];
        got.avg = out_tdata[CH_W+1 +: AVG_W];
        got.thr = out_tdata[CH_W+1+AVG_W +: THR_W];
        got.bad = out_tuser;
        if (pending_detections.size() == 0) begin
          flag_mismatch("unrequested result word", out_tdata, 0);
        end else begin
          want = pending_detections.pop_front();
          if (got.ch != want.ch) flag_mismatch("channel_out", got.ch, want.ch);
          if (got.act != want.act) flag_mismatch("active", got.act, want.act);
          if (got.avg != want.avg) flag_mismatch("average", got.avg, want.avg);
          if (got.thr != want.thr) flag_mismatch("threshold", got.thr, want.thr);
          if (got.bad != want.bad) flag_mismatch("bad_channel", got.bad, want.bad);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[CFG_AW-1:2] == REG_GAIN) begin
        if (cfg_pwrite) begin
          gain = cfg_pwdata[GAIN_W-1:0];
        end else if (cfg_prdata != CFG_DW'(gain)) begin
          flag_mismatch("range_gain_q10 readback", cfg_prdata, gain);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_detections = {pending_detections,
                              detect_occupancy(in_tdata[CH_W-1:0], in_tdata[CH_W +: SB])};
      end
    end
    open_words <= pending_detections.size();
  end

endmodule

// ----- test/adaptive_threshold_occupancy_detector_test.sv -----
`timescale 1ns / 100ps

module adaptive_threshold_occupancy_detector_test;
  import atod_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SAMPLE_MAX   = (1 << SB) - 1;
  localparam int SEGMENT_LEN  = 160;
  localparam logic [CFG_AW-1:0] GAIN_ADDR     = {REG_GAIN, 2'b00};
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = {~REG_GAIN, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int open_words;
  int mismatches;
  int send_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  adaptive_threshold_occupancy_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  occupancy_checker occupancy_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .open_words (open_words),
    .mismatches (mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < rcv_idle_pct) begin
      stall_left <= $urandom_range(0, 20);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_sample(input int ch, input int s);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (s < 0) s = 0;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-CH_W-SB){1'b0}}, SB'(s), CH_W'(ch)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // A write, if any, is always followed by a readback of the gain register.
  task automatic program_reg(input logic do_write, input logic [CFG_AW-1:0] addr,
                             input int unsigned value);
    if (do_write) cfg_access(1'b1, addr, ($urandom & ~32'h3FF) | value);
    cfg_access(1'b0, GAIN_ADDR, $urandom);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Most bursts follow a steady baseline on one channel with noise and the odd
  // spike; the rest are zero runs that empty a window, full-range noise and extremes.
  task automatic run_segment(input int count);
    int left, mode, len, base, spread, s;
    logic [CH_W-1:0] ch;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(0, 9);
      ch = CH_W'($urandom_range(0, (1 << CH_W) - 1));
      len = (mode == 5) ? $urandom_range(33, 40) : $urandom_range(1, 40);
      if (mode >= 8) begin
        base = $urandom_range(0, 16);
        spread = 3;
      end else begin
        base = $urandom_range(0, SAMPLE_MAX);
        spread = base / 8 + 1;
      end
      for (int k = 0; k < len && left > 0; k++) begin
        case (mode)
          5: s = 0;
          6: begin
            ch = CH_W'($urandom_range(0, (1 << CH_W) - 1));
            s = $urandom_range(0, SAMPLE_MAX);
          end
          7: s = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          default: begin
            s = base + int'($urandom_range(0, 2 * spread)) - spread;
            if ($urandom_range(0, 9) == 0) s = base + int'($urandom_range(0, SAMPLE_MAX - base));
          end
        endcase
        push_sample(int'(ch), s);
        left--;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_reg(1'b0, GAIN_ADDR, 0);

    push_sample(0, 0);
    push_sample(0, SAMPLE_MAX);
    push_sample(0, 0);
    push_sample(1, 1);
    push_sample(1, 1000);
    push_sample(1, 1000);
    push_sample(2, 'h2AAAA);
    push_sample(2, 'h15555);
    push_sample(3, SAMPLE_MAX);
    push_sample(3, SAMPLE_MAX);
    settle();
    program_reg(1'b1, GAIN_ADDR, 1023);
    push_sample(1, 500);
    push_sample(2, 0);
    push_sample(3, 1);
    push_sample(0, SAMPLE_MAX);
    settle();
    program_reg(1'b1, GAIN_ADDR, 0);
    push_sample(1, 2000);
    push_sample(3, 0);
    settle();
    program_reg(1'b1, UNMAPPED_ADDR, 'h3FF);
    push_sample(1, 10);
    push_sample(1, 5000);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0: program_reg(1'b1, GAIN_ADDR, 0);
        1: program_reg(1'b1, GAIN_ADDR, 1023);
        3: program_reg(1'b1, GAIN_ADDR, GAIN_RESET);
        default: program_reg(1'b1, GAIN_ADDR, $urandom_range(0, 1023));
      endcase
      send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 59 : 0;
      rcv_idle_pct  = (seg < 2) ? 59 : (seg < 4) ? 34 : 0;
      run_segment(SEGMENT_LEN);
    end
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/atod_pkg.sv
src/atod_div.sv
src/atod_core.sv
src/adaptive_threshold_occupancy_detector.sv
src/atod_checker.sv
test/occupancy_checker.sv
test/adaptive_threshold_occupancy_detector_test.sv
